FILE: rtl/q16_pkg.sv
// ----------------------------------------------------------------------------
// Q16 ALU package
// Operation codes and shared types of the fixed-point ALU.
// ----------------------------------------------------------------------------
package q16_pkg;

  localparam int ActionW = 3;

  localparam logic [ActionW-1:0] ACT_ADD  = 3'd0;
  localparam logic [ActionW-1:0] ACT_SUB  = 3'd1;
  localparam logic [ActionW-1:0] ACT_MUL  = 3'd2;
  localparam logic [ActionW-1:0] ACT_DIV  = 3'd3;
  localparam logic [ActionW-1:0] ACT_EQ   = 3'd4;
  localparam logic [ActionW-1:0] ACT_LT   = 3'd5;
  localparam logic [ActionW-1:0] ACT_INT  = 3'd6;
  localparam logic [ActionW-1:0] ACT_FRAC = 3'd7;

  typedef struct packed {
    logic                 valid;
    logic [ActionW-1:0]   action;
    logic                 negate;
    logic                 dz;
    logic                 cmp;
  } q16_ctl_t;

endpackage

FILE: rtl/q16_div_stage.sv
// ----------------------------------------------------------------------------
// Q16 divider stage
// One registered step group of the pipelined restoring divider.
// ----------------------------------------------------------------------------
module q16_div_stage #(
  parameter int NW    = 48,
  parameter int STEPS = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] quo_i,
  input  logic [NW:0]   rem_i,
  input  logic [31:0]   den_i,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o,
  output logic [NW:0]   rem_o,
  output logic [31:0]   den_o
);

  logic [NW-1:0] num_nxt;
  logic [NW-1:0] quo_nxt;
  logic [NW:0]   rem_nxt;
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [NW:0]   rem_r;
  logic [31:0]   den_r;

  always_comb begin
    logic [NW:0] trial;
    num_nxt = num_i;
    quo_nxt = quo_i;
    rem_nxt = rem_i;
    for (int i = 0; i < STEPS; i++) begin
      trial   = {rem_nxt[NW-1:0], num_nxt[NW-1]};
      num_nxt = {num_nxt[NW-2:0], 1'b0};
      if (trial >= {{(NW-31){1'b0}}, den_i}) begin
        rem_nxt = trial - {{(NW-31){1'b0}}, den_i};
        quo_nxt = {quo_nxt[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_nxt[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_i;
  end

  assign num_o = num_r;
  assign quo_o = quo_r;
  assign rem_o = rem_r;
  assign den_o = den_r;

endmodule

FILE: rtl/q16_fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// Q16.16 fixed-point ALU
// Pipelined signed fixed-point arithmetic unit.
//
// An operation beat is accepted on a rising edge with start high and busy
// low. busy is tied low: the pipeline takes one beat every cycle. Each beat
// gives exactly one result beat, shown on the out_ ports for one cycle while
// done is high. The divider sets the depth of the pipeline, eight quotient
// bits per stage, and all other operations travel alongside it so results
// leave in order. The receiver cannot stall the unit. A synchronous active-low
// reset clears all valid bits; results in flight are dropped. Data registers
// are not reset.
// ----------------------------------------------------------------------------
module q16_fixed_point_alu_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_action,
  input  logic signed [31:0]      in_operand_a,
  input  logic signed [31:0]      in_operand_b,
  output logic                    done,
  output logic signed [31:0]      out_result,
  output logic                    out_compare_true,
  output logic                    out_divide_by_zero
);

  localparam int NW     = 32 + FRACTION_BITS;
  localparam int STEPS  = 8;
  localparam int NSTAGE = (NW + STEPS - 1) / STEPS;
  localparam int PAD    = NSTAGE * STEPS;

  q16_pkg::q16_ctl_t ctl_r [NSTAGE+1];
  logic [31:0]       res_r [NSTAGE+1];
  logic [63:0]       prod_r;

  logic [PAD-1:0] num_w [NSTAGE+1];
  logic [PAD-1:0] quo_w [NSTAGE+1];
  logic [PAD:0]   rem_w [NSTAGE+1];
  logic [31:0]    den_w [NSTAGE+1];

  q16_pkg::q16_ctl_t ctl_nxt;
  logic [31:0]       res_nxt;
  logic [31:0]       mag_a;
  logic [31:0]       mag_b;
  logic [63:0]       prod_nxt;

  assign busy  = 1'b0;
  assign mag_a = in_operand_a[31] ? 32'(-in_operand_a) : in_operand_a;
  assign mag_b = in_operand_b[31] ? 32'(-in_operand_b) : in_operand_b;
  assign prod_nxt = 64'($signed(in_operand_a) * $signed(in_operand_b));

  always_comb begin
    logic [31:0] ipart;
    ipart = (mag_a >> FRACTION_BITS) << FRACTION_BITS;
    ctl_nxt.valid  = start;
    ctl_nxt.action = in_action;
    ctl_nxt.negate = 1'b0;
    ctl_nxt.dz     = 1'b0;
    ctl_nxt.cmp    = 1'b0;
    res_nxt        = '0;
    case (in_action)
      q16_pkg::ACT_ADD:  res_nxt = 32'(in_operand_a + in_operand_b);
      q16_pkg::ACT_SUB:  res_nxt = 32'(in_operand_a - in_operand_b);
      q16_pkg::ACT_MUL:  res_nxt = '0;
      q16_pkg::ACT_DIV: begin
        ctl_nxt.dz     = (in_operand_b == 32'sd0);
        ctl_nxt.negate = in_operand_a[31] ^ in_operand_b[31];
      end
      q16_pkg::ACT_EQ:   ctl_nxt.cmp = (in_operand_a == in_operand_b);
      q16_pkg::ACT_LT:   ctl_nxt.cmp = (in_operand_a < in_operand_b);
      q16_pkg::ACT_INT:  res_nxt = in_operand_a[31] ? 32'(-ipart) : ipart;
      q16_pkg::ACT_FRAC: res_nxt = mag_a & ((32'd1 << FRACTION_BITS) - 32'd1);
      default:           res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else begin
      ctl_r[0].valid <= ctl_nxt.valid;
    end
    ctl_r[0].action <= ctl_nxt.action;
    ctl_r[0].negate <= ctl_nxt.negate;
    ctl_r[0].dz     <= ctl_nxt.dz;
    ctl_r[0].cmp    <= ctl_nxt.cmp;
    res_r[0]        <= res_nxt;
    prod_r          <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    num_w[0] <= {mag_a, {(PAD-32){1'b0}}};
    den_w[0] <= mag_b;
  end
  assign quo_w[0] = '0;
  assign rem_w[0] = '0;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_div
    q16_div_stage #(.NW(PAD), .STEPS(STEPS)) u_stage (
      .clk   (clk),
      .num_i (num_w[s]),
      .quo_i (quo_w[s]),
      .rem_i (rem_w[s]),
      .den_i (den_w[s]),
      .num_o (num_w[s+1]),
      .quo_o (quo_w[s+1]),
      .rem_o (rem_w[s+1]),
      .den_o (den_w[s+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1].valid <= 1'b0;
      end else begin
        ctl_r[s+1].valid <= ctl_r[s].valid;
      end
      ctl_r[s+1].action <= ctl_r[s].action;
      ctl_r[s+1].negate <= ctl_r[s].negate;
      ctl_r[s+1].dz     <= ctl_r[s].dz;
      ctl_r[s+1].cmp    <= ctl_r[s].cmp;
      if (s == 0 && ctl_r[s].action == q16_pkg::ACT_MUL) begin
        res_r[s+1] <= prod_r[FRACTION_BITS +: 32];
      end else begin
        res_r[s+1] <= res_r[s];
      end
    end
  end

  logic [31:0] quo_low;
  logic [31:0] div_res;
  logic [31:0] res_out_nxt;
  q16_pkg::q16_ctl_t ctl_last;
  logic done_r;
  logic [31:0] out_res_r;
  logic out_cmp_r;
  logic out_dz_r;

  assign ctl_last = ctl_r[NSTAGE];
  assign quo_low  = quo_w[NSTAGE][PAD-NW +: 32];
  assign div_res  = ctl_last.negate ? 32'(-quo_low) : quo_low;

  always_comb begin
    res_out_nxt = res_r[NSTAGE];
    if (ctl_last.action == q16_pkg::ACT_DIV) begin
      res_out_nxt = ctl_last.dz ? 32'd0 : div_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ctl_last.valid;
    end
    out_res_r <= res_out_nxt;
    out_cmp_r <= ctl_last.cmp;
    out_dz_r  <= ctl_last.dz;
  end

  assign done               = done_r;
  assign out_result         = out_res_r;
  assign out_compare_true   = out_cmp_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

FILE: sim/q16_fixed_point_alu_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q16.16 fixed-point ALU testbench
// Drives directed and random operation beats in random bursts, predicts each
// result with a behavioral Q16.16 model and checks every result beat in order.
// ----------------------------------------------------------------------------
module q16_fixed_point_alu_unit_tb;

  localparam int ActW = q16_pkg::ActionW;
  localparam int FracBits = 16;
  localparam int Latency = 2 + (32 + FracBits + 7) / 8;
  localparam int WatchdogLimit = 2000;
  localparam int NumRandom = 650;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [31:0]     a;
    logic [31:0]     b;
  } alu_op_t;

  typedef struct packed {
    logic [31:0] result;
    logic        cmp;
    logic        dz;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_action = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic done;
  logic signed [31:0] out_result;
  logic out_compare_true;
  logic out_divide_by_zero;

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int error_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit stim_done = 1'b0;
  bit drain_hold = 1'b0;
  logic [7:0] action_seen = '0;

  q16_fixed_point_alu_unit #(.FRACTION_BITS(FracBits)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .done(done), .out_result(out_result),
    .out_compare_true(out_compare_true), .out_divide_by_zero(out_divide_by_zero)
  );

  always #1 clk = ~clk;

  function automatic alu_res_t compute_q16(alu_op_t op);
    alu_res_t r;
    logic signed [63:0] sa, sb, prod;
    logic [63:0] ma, mb, q;
    sa = {{32{op.a[31]}}, op.a};
    sb = {{32{op.b[31]}}, op.b};
    ma = sa[63] ? -sa : sa;
    mb = sb[63] ? -sb : sb;
    r = '0;
    case (op.action)
      q16_pkg::ACT_ADD: r.result = op.a + op.b;
      q16_pkg::ACT_SUB: r.result = op.a - op.b;
      q16_pkg::ACT_MUL: begin
        prod = sa * sb;
        prod = prod >>> FracBits;
        r.result = prod[31:0];
      end
      q16_pkg::ACT_DIV: begin
        if (op.b == 32'd0) begin
          r.dz = 1'b1;
        end else begin
          q = (ma << FracBits) / mb;
          if (sa[63] != sb[63]) q = -q;
          r.result = q[31:0];
        end
      end
      q16_pkg::ACT_EQ: r.cmp = (sa == sb);
      q16_pkg::ACT_LT: r.cmp = (sa < sb);
      q16_pkg::ACT_INT: begin
        q = (ma >> FracBits) << FracBits;
        if (sa[63]) q = -q;
        r.result = q[31:0];
      end
      default: r.result = {16'd0, ma[15:0]};
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at beat %0d: %s got %h expected %h", beats_checked, what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      4: return {16'($urandom), 16'd0};
      5: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FracBits;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic [ActW-1:0] act, logic [31:0] a, logic [31:0] b);
    pending_ops.push_back('{action: act, a: a, b: b});
  endtask

  initial begin
    logic [31:0] a, b;
    push_op(q16_pkg::ACT_ADD, 32'h7fff_ffff, 32'h0000_0001);
    push_op(q16_pkg::ACT_SUB, 32'h8000_0000, 32'h0000_0001);
    push_op(q16_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000);
    push_op(q16_pkg::ACT_MUL, 32'hffff_ffff, 32'h0000_0001);
    push_op(q16_pkg::ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    push_op(q16_pkg::ACT_DIV, 32'h0001_0000, 32'h0000_0000);
    push_op(q16_pkg::ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
    push_op(q16_pkg::ACT_DIV, 32'hfffe_0000, 32'h0003_0000);
    push_op(q16_pkg::ACT_DIV, 32'h7fff_ffff, 32'h0000_0001);
    push_op(q16_pkg::ACT_EQ, 32'h1234_5678, 32'h1234_5678);
    push_op(q16_pkg::ACT_EQ, 32'h8000_0000, 32'h7fff_ffff);
    push_op(q16_pkg::ACT_LT, 32'h8000_0000, 32'h7fff_ffff);
    push_op(q16_pkg::ACT_LT, 32'h7fff_ffff, 32'h8000_0000);
    push_op(q16_pkg::ACT_INT, 32'hfffe_8000, 32'h0);
    push_op(q16_pkg::ACT_INT, 32'h8000_0000, 32'hffff_ffff);
    push_op(q16_pkg::ACT_INT, 32'h7fff_ffff, 32'h0);
    push_op(q16_pkg::ACT_FRAC, 32'hfffe_8000, 32'h0);
    push_op(q16_pkg::ACT_FRAC, 32'h8000_0000, 32'hffff_ffff);
    push_op(q16_pkg::ACT_FRAC, 32'h7fff_ffff, 32'h0);
    for (int i = 0; i < NumRandom; i++) begin
      a = pick_operand();
      b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
      if ($urandom_range(0, 7) == 0) b = a;
      push_op(ActW'($urandom_range(0, 7)), a, b);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    alu_op_t op;
    bit fire;
    fire = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(compute_q16({in_action, in_operand_a, in_operand_b}));
        action_seen[in_action] = 1'b1;
        beats_sent++;
      end
      if (beats_sent == 200 && !drain_hold && expected_results.size() != 0) begin
        drain_hold = 1'b1;
      end else if (drain_hold && beats_sent == 200 && expected_results.size() != 0) begin
        drain_hold = 1'b1;
      end else if (beats_sent > 200 || expected_results.size() == 0) begin
        drain_hold = 1'b0;
      end
      if (!(start && busy)) begin
        if (beats_sent == 200 && expected_results.size() != 0) begin
          fire = 1'b0;
        end else if (burst_left > 0 && pending_ops.size() != 0) begin
          fire = 1'b1;
          burst_left--;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (fire) begin
          op = pending_ops.pop_front();
          in_action <= op.action;
          in_operand_a <= op.a;
          in_operand_b <= op.b;
        end
        start <= fire;
        if (!fire && pending_ops.size() == 0) stim_done = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_result, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_result !== want.result) report_mismatch("result", out_result, want.result);
        if (out_compare_true !== want.cmp)
          report_mismatch("compare_true", 32'(out_compare_true), 32'(want.cmp));
        if (out_divide_by_zero !== want.dz)
          report_mismatch("divide_by_zero", 32'(out_divide_by_zero), 32'(want.dz));
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (!stim_done && idle_cycles < WatchdogLimit) @(posedge clk);
    while (expected_results.size() != 0 && idle_cycles < WatchdogLimit) @(posedge clk);
    if (idle_cycles >= WatchdogLimit) begin
      $display("q16_fixed_point_alu_unit_tb: done, errors");
    end else begin
      repeat (Latency + 4) @(posedge clk);
      $display("Sent %0d beats, checked %0d results, actions seen mask %b.",
               beats_sent, beats_checked, action_seen);
      if (error_count == 0 && expected_results.size() == 0) begin
        $display("q16_fixed_point_alu_unit_tb: done, clean");
      end else begin
        $display("q16_fixed_point_alu_unit_tb: done, errors");
      end
    end
    $finish;
  end

endmodule
